FILE: sv/dtp_pkg.sv
// Package for the DER TLV stream parser.
// Holds the shared constants, the status codes and the result record type.
// No dependencies.
package dtp_pkg;

    localparam int MAX_DER_BYTES = 4;
    localparam int LEFT_W        = $clog2(MAX_DER_BYTES + 1);
    localparam int ACC_W         = 32;
    localparam int LEN_W         = 16;

    localparam logic [1:0] TAG_MODE_8  = 2'd0;
    localparam logic [1:0] TAG_MODE_16 = 2'd1;
    localparam logic [1:0] TAG_MODE_RESET = 2'd2;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_MSG_OK  = 3'd1,
        ST_BADSIZE = 3'd2,
        ST_TOOBIG  = 3'd3,
        ST_TRUNC   = 3'd4,
        ST_DISCARD = 3'd5
    } status_t;

    typedef struct packed {
        logic [ACC_W-1:0] tag_value;
        logic [LEN_W-1:0] length_value;
        logic [7:0]       value_byte;
        logic             value_valid;
        logic             header_done;
        logic             record_done;
        status_t          status;
    } result_t;

endpackage

FILE: sv/dtp_if.sv
// Request channel interfaces for the DER TLV stream parser.
// dtp_msg_if carries message bytes, dtp_res_if carries parse results; uses dtp_pkg.
interface dtp_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dtp_res_if import dtp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACC_W-1:0] tag_value;
    logic [LEN_W-1:0] length_value;
    logic [7:0]       value_byte;
    logic             value_valid;
    logic             header_done;
    logic             record_done;
    status_t          status;

    modport source (
        output valid, output tag_value, output length_value, output value_byte,
        output value_valid, output header_done, output record_done, output status,
        input ready
    );
    modport sink (
        input valid, input tag_value, input length_value, input value_byte,
        input value_valid, input header_done, input record_done, input status,
        output ready
    );
endinterface

FILE: sv/dtp_core.sv
// Parser state and per-byte decode for the DER TLV stream parser.
// Holds the tag width register and the record state; uses dtp_pkg.
module dtp_core
    import dtp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    output result_t    res
);

    typedef enum logic [2:0] {
        PH_TAG_FIRST,
        PH_TAG_LONG,
        PH_LEN_FIRST,
        PH_LEN_LONG,
        PH_VALUE,
        PH_DISCARD
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [LEFT_W-1:0]  long_left_reg, long_left_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   tag_reg, tag_next;
    logic [LEN_W-1:0]   vleft_reg, vleft_next;
    logic [1:0]         mode_reg;

    logic [ACC_W-1:0]   acc_shift;
    logic [ACC_W-1:0]   fin_val;
    logic [ACC_W-1:0]   tag_limit;
    logic [LEFT_W-1:0]  left_dec;
    logic [6:0]         long_size;
    logic               is_len;
    logic               fin;
    logic               err;
    status_t            err_code;
    status_t            status;
    logic               hdone;
    logic               rdone;
    logic               vvalid;
    logic [LEN_W-1:0]   len;

    assign acc_shift = {acc_reg[ACC_W-9:0], data_byte};
    assign left_dec  = long_left_reg - LEFT_W'(1);
    assign long_size = data_byte[6:0];
    assign is_len    = (phase_reg == PH_LEN_FIRST) || (phase_reg == PH_LEN_LONG);

    always_comb
    begin
        case (mode_reg)
            TAG_MODE_8:  tag_limit = ACC_W'(32'h0000_00FF);
            TAG_MODE_16: tag_limit = ACC_W'(32'h0000_FFFF);
            default:     tag_limit = '1;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        long_left_next = long_left_reg;
        acc_next       = acc_reg;
        tag_next       = tag_reg;
        vleft_next     = vleft_reg;
        fin            = 1'b0;
        fin_val        = '0;
        err            = 1'b0;
        err_code       = ST_BUSY;
        status         = ST_BUSY;
        hdone          = 1'b0;
        rdone          = 1'b0;
        vvalid         = 1'b0;
        len            = '0;

        case (phase_reg)
            PH_TAG_FIRST, PH_LEN_FIRST:
            begin
                if (data_byte[7])
                begin
                    if (!is_len)
                    begin
                        tag_next = '0;
                    end
                    if (last_byte && (long_size != 7'd0))
                    begin
                        err      = 1'b1;
                        err_code = ST_TRUNC;
                    end
                    else if ((long_size == 7'd0) || (long_size > 7'(MAX_DER_BYTES)))
                    begin
                        err      = 1'b1;
                        err_code = ST_BADSIZE;
                    end
                    else
                    begin
                        long_left_next = long_size[LEFT_W-1:0];
                        acc_next       = '0;
                        phase_next     = is_len ? PH_LEN_LONG : PH_TAG_LONG;
                    end
                end
                else
                begin
                    fin     = 1'b1;
                    fin_val = ACC_W'(data_byte);
                end
            end
            PH_TAG_LONG, PH_LEN_LONG:
            begin
                acc_next       = acc_shift;
                long_left_next = left_dec;
                if (left_dec == '0)
                begin
                    fin     = 1'b1;
                    fin_val = acc_shift;
                end
                else if (last_byte)
                begin
                    err      = 1'b1;
                    err_code = ST_TRUNC;
                end
            end
            PH_VALUE:
            begin
                vvalid     = 1'b1;
                vleft_next = vleft_reg - LEN_W'(1);
                if (vleft_next == '0)
                begin
                    rdone      = 1'b1;
                    phase_next = PH_TAG_FIRST;
                    if (last_byte)
                    begin
                        status = ST_MSG_OK;
                    end
                end
                else if (last_byte)
                begin
                    err      = 1'b1;
                    err_code = ST_TRUNC;
                end
            end
            default:
            begin
                status     = ST_DISCARD;
                tag_next   = '0;
                phase_next = last_byte ? PH_TAG_FIRST : PH_DISCARD;
            end
        endcase

        if (fin)
        begin
            if (!is_len)
            begin
                if (fin_val > tag_limit)
                begin
                    err      = 1'b1;
                    err_code = ST_TOOBIG;
                end
                else
                begin
                    tag_next   = fin_val;
                    phase_next = PH_LEN_FIRST;
                    if (last_byte)
                    begin
                        err      = 1'b1;
                        err_code = ST_TRUNC;
                    end
                end
            end
            else if (fin_val[ACC_W-1:LEN_W] != '0)
            begin
                err      = 1'b1;
                err_code = ST_TOOBIG;
            end
            else
            begin
                hdone = 1'b1;
                len   = fin_val[LEN_W-1:0];
                if (len == '0)
                begin
                    rdone      = 1'b1;
                    phase_next = PH_TAG_FIRST;
                end
                else
                begin
                    vleft_next = len;
                    phase_next = PH_VALUE;
                end
                if (last_byte)
                begin
                    err      = 1'b1;
                    err_code = ST_TRUNC;
                end
            end
        end

        if (err)
        begin
            status         = err_code;
            tag_next       = '0;
            long_left_next = '0;
            acc_next       = '0;
            vleft_next     = '0;
            phase_next     = last_byte ? PH_TAG_FIRST : PH_DISCARD;
        end
    end

    always_comb
    begin
        res = '0;
        res.status = status;
        if ((status == ST_BUSY) || (status == ST_MSG_OK))
        begin
            res.tag_value    = tag_next;
            res.length_value = len;
            res.value_byte   = vvalid ? data_byte : 8'd0;
            res.value_valid  = vvalid;
            res.header_done  = hdone;
            res.record_done  = rdone;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TAG_FIRST;
            long_left_reg <= '0;
            acc_reg       <= '0;
            tag_reg       <= '0;
            vleft_reg     <= '0;
            mode_reg      <= TAG_MODE_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                phase_reg     <= phase_next;
                long_left_reg <= long_left_next;
                acc_reg       <= acc_next;
                tag_reg       <= tag_next;
                vleft_reg     <= vleft_next;
            end
        end
    end

    // A byte carrying the last mark always leaves the parser ready for a new message.
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> phase_reg == PH_TAG_FIRST)
        else $error("parser not idle after last byte");

    a_hdr_to_value: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.header_done && (res.length_value != '0) && !last_byte
        |=> phase_reg == PH_VALUE)
        else $error("non-empty header did not enter value phase");

    a_value_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_VALUE |-> vleft_reg != '0)
        else $error("value phase with no bytes left");

    a_long_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TAG_LONG) || (phase_reg == PH_LEN_LONG)
        |-> (long_left_reg != '0) && (long_left_reg <= LEFT_W'(MAX_DER_BYTES)))
        else $error("long-form byte count out of range");

    a_hdr_rec: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.header_done && res.record_done |-> res.length_value == '0)
        else $error("record closed by a header with non-zero length");

endmodule

FILE: sv/dtp_out_buf.sv
// Output register with a skid stage for the DER TLV stream parser.
// Decouples the result channel from the message channel; uses dtp_pkg and dtp_res_if.
module dtp_out_buf
    import dtp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  result_t    push_data,
    output logic       can_push,
    dtp_res_if.source  result
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    assign can_push = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || result.ready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.tag_value    = out_data_reg.tag_value;
    assign result.length_value = out_data_reg.length_value;
    assign result.value_byte   = out_data_reg.value_byte;
    assign result.value_valid  = out_data_reg.value_valid;
    assign result.header_done  = out_data_reg.header_done;
    assign result.record_done  = out_data_reg.record_done;
    assign result.status       = out_data_reg.status;

endmodule

FILE: sv/der_tlv_stream_parser.sv
// Top level of the DER TLV stream parser: one message byte in, one result out.
// Each result is registered in the output register, or in the skid register on a stall.
// Throughput: one byte per cycle while the skid register of the output buffer is empty.
// A two-entry output buffer keeps taking bytes while one result waits to be taken.
// Reset (rst_n, asynchronous) returns the parser to the tag phase and sets 32-bit tags.
// Depends on dtp_pkg, dtp_if, dtp_core and dtp_out_buf.
module der_tlv_stream_parser
    import dtp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dtp_msg_if.sink    msg,
    dtp_res_if.source  result,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data
);

    logic    accept;
    logic    can_push;
    result_t res;

    assign msg.ready = can_push;
    assign accept    = msg.valid && can_push;

    dtp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (msg.data_byte),
        .last_byte   (msg.last_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res         (res)
    );

    dtp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .can_push  (can_push),
        .result    (result)
    );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for der_tlv_stream_parser: random and directed TLV messages, with idling on both
// request channels, checked against a built-in byte-level parse predictor.
// Depends on dtp_pkg, dtp_if and the parser RTL.
module tb_top;
    import dtp_pkg::*;

    localparam logic [1:0] TAG_MODE_32     = TAG_MODE_RESET;
    localparam logic [1:0] TAG_MODE_32_ALT = 2'd3;
    localparam int         CYCLE_LIMIT     = 300000;

    typedef enum logic [2:0] {
        P_TAG_FIRST,
        P_TAG_LONG,
        P_LEN_FIRST,
        P_LEN_LONG,
        P_VALUE,
        P_DISCARD
    } parse_phase_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [1:0] cfg_wr_data;

    dtp_msg_if msg_ch ();
    dtp_res_if res_ch ();

    der_tlv_stream_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg         (msg_ch),
        .result      (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    parse_phase_t ps_phase = P_TAG_FIRST;
    logic [2:0]   ps_long_left = '0;
    logic [31:0]  ps_acc = '0;
    logic [31:0]  ps_tag = '0;
    logic [15:0]  ps_value_left = '0;
    logic [1:0]   ps_tag_mode = TAG_MODE_RESET;
    result_t      ps_out;

    result_t     pending_parse_results[$];
    logic [7:0]  frame_q[$];
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;
    int          gap_max = 0;
    int          burst_left = 0;
    int          stall_pct = 0;
    int          hold_left = 0;
    int          run_left = 0;

    function automatic logic [31:0] tag_limit(logic [1:0] mode);
        if (mode == TAG_MODE_8)
            return 32'hFF;
        if (mode == TAG_MODE_16)
            return 32'hFFFF;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic void raise_error(status_t code, logic last);
        ps_out.status = code;
        ps_tag = '0;
        ps_long_left = '0;
        ps_acc = '0;
        ps_value_left = '0;
        ps_phase = last ? P_TAG_FIRST : P_DISCARD;
    endfunction

    function automatic void close_field(logic [31:0] v, logic last, logic is_len);
        if (!is_len)
        begin
            if (v > tag_limit(ps_tag_mode))
                raise_error(ST_TOOBIG, last);
            else
            begin
                ps_tag = v;
                ps_phase = P_LEN_FIRST;
                if (last)
                    raise_error(ST_TRUNC, last);
            end
        end
        else if (v > 32'hFFFF)
            raise_error(ST_TOOBIG, last);
        else
        begin
            ps_out.header_done = 1'b1;
            ps_out.length_value = v[15:0];
            if (v == 0)
            begin
                ps_out.record_done = 1'b1;
                ps_phase = P_TAG_FIRST;
            end
            else
            begin
                ps_value_left = v[15:0];
                ps_phase = P_VALUE;
            end
            if (last)
                raise_error(ST_TRUNC, last);
        end
    endfunction

    function automatic void open_field(logic [7:0] b, logic last, logic is_len);
        logic [6:0] n;
        n = b[6:0];
        if (b[7])
        begin
            if (!is_len)
                ps_tag = '0;
            if (last && n != 0)
                raise_error(ST_TRUNC, last);
            else if (n == 0 || n > MAX_DER_BYTES)
                raise_error(ST_BADSIZE, last);
            else
            begin
                ps_long_left = n[2:0];
                ps_acc = '0;
                ps_phase = is_len ? P_LEN_LONG : P_TAG_LONG;
            end
        end
        else
            close_field({24'd0, b}, last, is_len);
    endfunction

    function automatic void long_field_byte(logic [7:0] b, logic last, logic is_len);
        ps_acc = {ps_acc[23:0], b};
        if (ps_long_left > 0)
            ps_long_left = ps_long_left - 3'd1;
        if (ps_long_left == 0)
            close_field(ps_acc, last, is_len);
        else if (last)
            raise_error(ST_TRUNC, last);
    endfunction

    function automatic result_t parse_byte(logic [7:0] b, logic last);
        status_t code;
        ps_out = '0;
        ps_out.status = ST_BUSY;
        case (ps_phase)
            P_TAG_FIRST: open_field(b, last, 1'b0);
            P_TAG_LONG:  long_field_byte(b, last, 1'b0);
            P_LEN_FIRST: open_field(b, last, 1'b1);
            P_LEN_LONG:  long_field_byte(b, last, 1'b1);
            P_VALUE:
            begin
                ps_out.value_valid = 1'b1;
                ps_out.value_byte = b;
                if (ps_value_left > 0)
                    ps_value_left = ps_value_left - 16'd1;
                if (ps_value_left == 0)
                begin
                    ps_out.record_done = 1'b1;
                    ps_phase = P_TAG_FIRST;
                    if (last)
                        ps_out.status = ST_MSG_OK;
                end
                else if (last)
                    raise_error(ST_TRUNC, last);
            end
            default:
            begin
                ps_out.status = ST_DISCARD;
                ps_tag = '0;
                ps_phase = last ? P_TAG_FIRST : P_DISCARD;
            end
        endcase
        if (ps_out.status >= ST_BADSIZE)
        begin
            code = ps_out.status;
            ps_out = '0;
            ps_out.status = code;
        end
        else
            ps_out.tag_value = ps_tag;
        return ps_out;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_parse_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n)
        begin
            if (msg_ch.valid && msg_ch.ready)
                pending_parse_results.push_back(parse_byte(msg_ch.data_byte, msg_ch.last_byte));
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_parse_results.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, status %0d", $time,
                             res_ch.status);
                    fail_count++;
                end
                else
                begin
                    want = pending_parse_results.pop_front();
                    check_field("tag_value", want.tag_value, res_ch.tag_value);
                    check_field("length_value", 32'(want.length_value),
                                32'(res_ch.length_value));
                    check_field("value_byte", 32'(want.value_byte), 32'(res_ch.value_byte));
                    check_field("value_valid", 32'(want.value_valid),
                                32'(res_ch.value_valid));
                    check_field("header_done", 32'(want.header_done),
                                32'(res_ch.header_done));
                    check_field("record_done", 32'(want.record_done),
                                32'(res_ch.record_done));
                    check_field("status", 32'(want.status), 32'(res_ch.status));
                end
            end
            if (cfg_wr_en)
                ps_tag_mode = cfg_wr_data;
        end
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (run_left > 0)
                run_left--;
            else
            begin
                run_left = $urandom_range(0, 5);
                res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_byte(logic [7:0] d, logic last);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (gap_max > 0)
                gap = $urandom_range(0, gap_max);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        msg_ch.valid <= 1'b1;
        msg_ch.data_byte <= d;
        msg_ch.last_byte <= last;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic wait_drain();
        @(negedge clk);
        msg_ch.valid <= 1'b0;
        while (pending_parse_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_tag_mode(logic [1:0] mode);
        wait_drain();
        repeat (2) @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void add_der(logic [31:0] v, int n);
        int i;
        if (n == 0)
            frame_q.push_back(v[7:0]);
        else
        begin
            frame_q.push_back(8'h80 | n[7:0]);
            for (i = n - 1; i >= 0; i--)
                frame_q.push_back(v[8*i +: 8]);
        end
    endfunction

    function automatic int der_size(logic [31:0] v);
        int m;
        if (v < 128)
            m = 0;
        else if (v <= 32'hFF)
            m = 1;
        else if (v <= 32'hFFFF)
            m = 2;
        else if (v <= 32'hFF_FFFF)
            m = 3;
        else
            m = 4;
        if (m == 0)
            return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        return $urandom_range(m, 4);
    endfunction

    function automatic logic [31:0] pick_tag();
        logic [31:0] t;
        t = $urandom;
        case ($urandom_range(0, 3))
            0: t = t & 32'h7F;
            1: t = t & 32'hFF;
            2: t = t & 32'hFFFF;
            default: ;
        endcase
        if ($urandom_range(0, 9) != 0)
            t = t & tag_limit(ps_tag_mode);
        return t;
    endfunction

    function automatic logic [31:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 4);
        if (r < 90)
            return $urandom_range(5, 24);
        if (r < 95)
            return $urandom_range(25, 64);
        if (r < 98)
            return $urandom_range(65, 65535);
        return 32'h1_0000 + ($urandom & 32'h00FF_FFFF);
    endfunction

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    task automatic build_frame();
        int kind;
        int nrec;
        int r;
        int cut;
        logic [31:0] tag;
        logic [31:0] len;
        kind = $urandom_range(0, 9);
        if (kind == 9)
        begin
            repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        nrec = $urandom_range(1, 4);
        for (r = 0; r < nrec; r++)
        begin
            tag = pick_tag();
            len = pick_length();
            if (r == nrec - 1 && len == 0 && $urandom_range(0, 3) != 0)
                len = 1;
            add_der(tag, der_size(tag));
            add_der(len, der_size(len));
            if (len <= 64)
                repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        if (kind == 7)
        begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
        end
        else if (kind == 8)
        begin
            cut = $urandom_range(0, frame_q.size() - 1);
            if ($urandom_range(0, 1) == 0)
                frame_q[cut] = 8'($urandom_range(0, 255));
            else
                frame_q.insert(cut, 8'h80 | 8'($urandom_range(5, 127)));
        end
    endtask

    task automatic send_random_traffic(int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            build_frame();
            send_frame();
        end
    endtask

    task automatic test_directed();
        // A short-form record whose value bytes carry both extremes and end the message.
        add_der(32'h01, 0); add_der(2, 0); add_der(32'h00, 0); add_der(32'hFF, 0);
        send_frame();
        // A zero-length record mid-message, then the largest tag in long form.
        add_der(32'h7F, 0); add_der(0, 0);
        add_der(32'hFFFF_FFFF, 4); add_der(1, 1); add_der(32'hAA, 0);
        send_frame();
        // A zero-length record ending the message is a truncation.
        add_der(0, 0); add_der(0, 0);
        send_frame();
        // Long-form size of zero, followed by discarded bytes.
        add_der(32'h80, 0); add_der(32'h11, 0); add_der(32'h22, 0);
        send_frame();
        // An oversize long-form header on the last byte is reported as truncation.
        add_der(32'h85, 0);
        send_frame();
        // The largest length, cut short in its value.
        add_der(32'h01, 0); add_der(32'hFFFF, 2); add_der(32'h33, 0);
        send_frame();
        // A length beyond 16 bits on the last byte.
        add_der(32'h01, 0); add_der(32'h1_0000, 3);
        send_frame();
        // A long-form size of zero on the last byte.
        add_der(32'h02, 0); add_der(32'h80, 0);
        send_frame();
        wait_drain();
    endtask

    task automatic test_tag_modes();
        logic [1:0] modes[4];
        logic [31:0] lim;
        int k;
        modes[0] = TAG_MODE_8;
        modes[1] = TAG_MODE_16;
        modes[2] = TAG_MODE_32_ALT;
        modes[3] = TAG_MODE_32;
        stall_pct = 20;
        gap_max = 2;
        for (k = 0; k < 4; k++)
        begin
            set_tag_mode(modes[k]);
            lim = tag_limit(modes[k]);
            add_der(lim, 4); add_der(1, 0); add_der($urandom_range(0, 255), 0);
            send_frame();
            if (lim != 32'hFFFF_FFFF)
            begin
                add_der(lim + 1, 4); add_der(0, 0); add_der(0, 0);
                send_frame();
            end
            send_random_traffic(60);
        end
    endtask

    task automatic test_backpressure();
        wait_drain();
        gap_max = 0;
        hold_left = 400;
        send_random_traffic(100);
        wait_drain();
        repeat (5) @(posedge clk);
    endtask

    task automatic test_random();
        int p;
        for (p = 0; p < 5; p++)
        begin
            if (p == 0)
            begin
                stall_pct = 0;
                gap_max = 0;
            end
            else
            begin
                stall_pct = $urandom_range(10, 70);
                gap_max = $urandom_range(0, 8);
            end
            if (p > 0)
                set_tag_mode(2'($urandom_range(0, 3)));
            send_random_traffic(260);
        end
        set_tag_mode(TAG_MODE_8);
        send_random_traffic(100);
    endtask

    initial
    begin
        rst_n = 1'b0;
        msg_ch.valid = 1'b0;
        msg_ch.data_byte = '0;
        msg_ch.last_byte = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_tag_modes();
        test_backpressure();
        test_random();
        wait_drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_parse_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
